// ===== sv/ifl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifl_pkg
// Shared types, widths and codes for the interval floor lookup table.
// ----------------------------------------------------------------------------
package ifl_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_WIDTH     = 32;
    localparam int VALUE_WIDTH   = 8;
    localparam int OPCODE_WIDTH  = 2;
    localparam int STATUS_WIDTH  = 3;

    typedef logic [KEY_WIDTH-1:0]    key_t;
    typedef logic [VALUE_WIDTH-1:0]  value_t;
    typedef logic [OPCODE_WIDTH-1:0] opcode_t;
    typedef logic [STATUS_WIDTH-1:0] status_t;

    localparam opcode_t OP_LOOKUP = 2'd0;
    localparam opcode_t OP_ASSIGN = 2'd1;
    localparam opcode_t OP_CLEAR  = 2'd2;

    localparam status_t ST_LOOKUP    = 3'd0;
    localparam status_t ST_ASSIGNED  = 3'd1;
    localparam status_t ST_BAD_ORDER = 3'd2;
    localparam status_t ST_SAME      = 3'd3;
    localparam status_t ST_FULL      = 3'd4;
    localparam status_t ST_CLEARED   = 3'd5;

    // Contents of one table entry as held by a cell.
    typedef struct packed {
        logic   valid;
        key_t   key;
        value_t value;
    } cell_state_t;

    // Command broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic   capture;
        logic   clear;
        logic   insert;
        logic   overwrite;
        key_t   probe_key;
        key_t   new_key;
        value_t new_value;
        value_t init_value;
    } cell_cmd_t;

endpackage

// ===== sv/ifl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifl_if
// Request and result channels of the interval floor lookup table.
// ----------------------------------------------------------------------------
interface ifl_req_if
    import ifl_pkg::*;
();
    logic    valid;
    logic    ready;
    opcode_t opcode;
    key_t    key;
    key_t    key_end;
    value_t  new_value;

    modport source (output valid, opcode, key, key_end, new_value, input ready);
    modport sink   (input valid, opcode, key, key_end, new_value, output ready);
endinterface

interface ifl_rsp_if
    import ifl_pkg::*;
();
    logic    valid;
    logic    ready;
    value_t  value;
    status_t status;

    modport source (output valid, value, status, input ready);
    modport sink   (input valid, value, status, output ready);
endinterface

// ===== sv/ifl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifl_cell
// One table entry: compares its start key and shifts from its left neighbor.
// ----------------------------------------------------------------------------
module ifl_cell
    import ifl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head,
    input  cell_cmd_t   cmd,
    input  cell_state_t prev_st,
    input  logic        prev_le_q,
    input  logic        next_le,
    output cell_state_t st,
    output logic        le,
    output logic        floor_hit,
    output logic        key_hit,
    output logic        le_q
);

    cell_state_t st_reg, st_next;
    logic        le_reg, floor_reg;

    // Entries are sorted, so the cells at or below the probe key form a prefix.
    assign le        = st_reg.valid && (st_reg.key <= cmd.probe_key);
    assign floor_hit = le && !next_le;
    assign key_hit   = floor_hit && (st_reg.key == cmd.probe_key);
    assign st        = st_reg;
    assign le_q      = le_reg;

    always_comb
    begin
        st_next = st_reg;
        if (cmd.clear)
        begin
            st_next.valid = head;
            st_next.key   = '0;
            st_next.value = head ? cmd.init_value : '0;
        end
        else if (cmd.insert && !le_reg)
        begin
            if (prev_le_q)
            begin
                st_next.valid = 1'b1;
                st_next.key   = cmd.new_key;
                st_next.value = cmd.new_value;
            end
            else
            begin
                st_next = prev_st;
            end
        end
        else if (cmd.overwrite && floor_reg)
        begin
            st_next.value = cmd.new_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= '{valid: head, key: '0, value: '0};
            le_reg    <= 1'b0;
            floor_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cmd.capture)
            begin
                le_reg    <= le;
                floor_reg <= floor_hit;
            end
        end
    end

endmodule

// ===== sv/interval_floor_lookup_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_floor_lookup_table
// Sorted start-key table with floor lookup, assign and clear.
//
//   channel | dir | handshake        | payload
//   req     | in  | valid / ready    | opcode, key, key_end, new_value
//   rsp     | out | valid / ready    | value, status
//   cfg     | in  | cfg_wr_en        | cfg_wr_data (initial value)
//
// For each word, the row of cells compares every start key with the request
// key in the accept cycle, and the update cycle shifts, writes or clears the
// row and loads the result register.
// Reset leaves one entry, key zero with value zero, and an initial value of 0.
// A full result register holds the update cycle until the word is taken.
// ----------------------------------------------------------------------------
module interval_floor_lookup_table
    import ifl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    ifl_req_if.sink      req,
    ifl_rsp_if.source    rsp,
    input  logic         cfg_wr_en,
    input  value_t       cfg_wr_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    opcode_t     op_reg;
    key_t        key_reg;
    value_t      new_value_reg;
    logic        order_ok_reg;
    value_t      existing_reg;
    logic        hit_reg;
    value_t      init_reg;

    logic        out_valid_reg, out_valid_next;
    value_t      out_value_reg, out_value_next;
    status_t     out_status_reg, out_status_next;

    cell_cmd_t   cmd;
    cell_state_t st      [DEPTH];
    logic [DEPTH-1:0] le_v, floor_v, hit_v, le_q_v;

    logic        accept;
    logic        commit;
    logic        full;
    value_t      existing;
    logic        hit;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign commit    = (state_reg == S_UPD) && (!out_valid_reg || rsp.ready);
    assign full      = st[DEPTH-1].valid;

    assign rsp.valid  = out_valid_reg;
    assign rsp.value  = out_value_reg;
    assign rsp.status = out_status_reg;

    // The floor flags are one-hot, so the covering value is an AND-OR select.
    always_comb
    begin
        existing = '0;
        hit      = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            existing = existing | (st[i].value & {VALUE_WIDTH{floor_v[i]}});
            hit      = hit | hit_v[i];
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.capture     = accept;
        cmd.probe_key   = req.key;
        cmd.new_key     = key_reg;
        cmd.new_value   = new_value_reg;
        cmd.init_value  = init_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        state_next      = state_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_value_next = existing_reg;
                    if (op_reg == OP_CLEAR)
                    begin
                        cmd.clear       = 1'b1;
                        out_value_next  = init_reg;
                        out_status_next = ST_CLEARED;
                    end
                    else if (op_reg != OP_ASSIGN)
                    begin
                        out_status_next = ST_LOOKUP;
                    end
                    else if (!order_ok_reg)
                    begin
                        out_status_next = ST_BAD_ORDER;
                    end
                    else if (existing_reg == new_value_reg)
                    begin
                        out_status_next = ST_SAME;
                    end
                    else if (hit_reg)
                    begin
                        cmd.overwrite   = 1'b1;
                        out_status_next = ST_ASSIGNED;
                    end
                    else if (full)
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.insert      = 1'b1;
                        out_status_next = ST_ASSIGNED;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            cell_state_t prev_st;
            logic        prev_le_q;
            logic        next_le;

            if (g == 0)
            begin : g_head
                assign prev_st   = '0;
                assign prev_le_q = 1'b1;
            end
            else
            begin : g_body
                assign prev_st   = st[g-1];
                assign prev_le_q = le_q_v[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign next_le = 1'b0;
            end
            else
            begin : g_inner
                assign next_le = le_v[g+1];
            end

            ifl_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .head      ((g == 0) ? 1'b1 : 1'b0),
                .cmd       (cmd),
                .prev_st   (prev_st),
                .prev_le_q (prev_le_q),
                .next_le   (next_le),
                .st        (st[g]),
                .le        (le_v[g]),
                .floor_hit (floor_v[g]),
                .key_hit   (hit_v[g]),
                .le_q      (le_q_v[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            init_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                init_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        if (accept)
        begin
            op_reg        <= req.opcode;
            key_reg       <= req.key;
            new_value_reg <= req.new_value;
            order_ok_reg  <= (req.key < req.key_end);
            existing_reg  <= existing;
            hit_reg       <= hit;
        end
    end

endmodule

// ===== sim/ifl_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifl_result_checker
// Watches the request, result and configuration ports of the interval floor
// lookup table. It keeps its own sorted copy of the start-key table, works out
// the answer to every accepted request word and compares each result word,
// field by field, with the oldest answer still awaited.
// ----------------------------------------------------------------------------
module ifl_result_checker
    import ifl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   cfg_wr_en,
    input  value_t cfg_wr_data,
    ifl_req_if     req,
    ifl_rsp_if     rsp,
    output int     fail_count,
    output int     pending_count,
    output int     checked_count,
    output int     full_count
);

    localparam int SHOWN_LIMIT = 10;

    typedef struct packed {
        value_t  value;
        status_t status;
    } table_answer_t;

    key_t          start_key [DEPTH];
    value_t        start_value [DEPTH];
    int            entry_count;
    value_t        init_value;
    table_answer_t answer_q [$];

    function automatic void reload_table(value_t v);
        int i;
        for (i = 0; i < DEPTH; i++)
        begin
            start_key[i]   = '0;
            start_value[i] = '0;
        end
        start_value[0] = v;
        entry_count    = 1;
    endfunction

    // Applies one request word to the table copy and returns its result word.
    function automatic table_answer_t run_table_op(opcode_t op, key_t k, key_t k_end,
                                                   value_t nv);
        table_answer_t ans;
        int            floor_idx;
        int            i;
        value_t        covering;
        if (op == OP_CLEAR)
        begin
            reload_table(init_value);
            ans.value  = init_value;
            ans.status = ST_CLEARED;
            return ans;
        end
        floor_idx = 0;
        for (i = 0; i < entry_count; i++)
        begin
            if (start_key[i] <= k)
                floor_idx = i;
        end
        covering   = start_value[floor_idx];
        ans.value  = covering;
        ans.status = ST_LOOKUP;
        if (op == OP_ASSIGN)
        begin
            if (!(k < k_end))
                ans.status = ST_BAD_ORDER;
            else if (covering == nv)
                ans.status = ST_SAME;
            else if (start_key[floor_idx] == k)
            begin
                start_value[floor_idx] = nv;
                ans.status             = ST_ASSIGNED;
            end
            else if (entry_count >= DEPTH)
            begin
                ans.status = ST_FULL;
                full_count++;
            end
            else
            begin
                // Make room right after the covering entry.
                for (i = entry_count; i > floor_idx + 1; i--)
                begin
                    start_key[i]   = start_key[i-1];
                    start_value[i] = start_value[i-1];
                end
                start_key[floor_idx+1]   = k;
                start_value[floor_idx+1] = nv;
                entry_count++;
                ans.status = ST_ASSIGNED;
            end
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_answer_t want;
        if (!rst_n)
        begin
            reload_table('0);
            init_value = '0;
            answer_q.delete();
            fail_count    = 0;
            pending_count = 0;
            checked_count = 0;
            full_count    = 0;
        end
        else
        begin
            if (cfg_wr_en)
                init_value = cfg_wr_data;
            if (req.valid && req.ready)
                answer_q.push_back(run_table_op(req.opcode, req.key, req.key_end,
                                                req.new_value));
            if (rsp.valid && rsp.ready)
            begin
                if (answer_q.size() == 0)
                begin
                    if (fail_count < SHOWN_LIMIT)
                        $display("%0t: result word with no request outstanding: value %02h status %0d",
                                 $realtime, rsp.value, rsp.status);
                    fail_count++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    checked_count++;
                    if (rsp.value !== want.value || rsp.status !== want.status)
                    begin
                        if (fail_count < SHOWN_LIMIT)
                            $display("%0t: mismatch: expected value %02h status %0d, got value %02h status %0d",
                                     $realtime, want.value, want.status, rsp.value, rsp.status);
                        fail_count++;
                    end
                end
            end
            pending_count = answer_q.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the interval floor lookup table with a directed opening (edge keys,
// every opcode, bad order, same value, a full table) and then random words
// under three idling patterns and three initial values, with one long result
// stall. A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;

    import ifl_pkg::*;

    localparam int      TABLE_DEPTH    = 16;
    localparam int      WATCHDOG_LIMIT = 4000;
    localparam int      DRAIN_CYCLES   = 8;
    localparam int      HOLD_CYCLES    = 80;
    localparam int      PHASE_WORDS    = 575;
    localparam opcode_t OP_UNUSED      = 2'd3;
    localparam key_t    KEY_MAX        = '1;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   cfg_wr_en   = 1'b0;
    value_t cfg_wr_data = '0;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int idle_cycles   = 0;

    int fail_count;
    int pending_count;
    int checked_count;
    int full_count;

    ifl_req_if req_ch ();
    ifl_rsp_if rsp_ch ();

    interval_floor_lookup_table #(
        .DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    ifl_result_checker #(
        .DEPTH (TABLE_DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .full_count    (full_count)
    );

    always #10 clk = ~clk;

    // Result side: random back-pressure, or a long hold-off when one is asked for.
    initial
    begin
        int hold_left;
        int holds_taken;
        hold_left    = 0;
        holds_taken  = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_taken != hold_requests)
            begin
                holds_taken = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(opcode_t op, key_t k, key_t k_end, value_t nv);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.key       <= k;
        req_ch.key_end   <= k_end;
        req_ch.new_value <= nv;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_initial_value(value_t v);
        req_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly a small key range so that assigns overwrite, repeat and fill up.
    function automatic key_t pick_key();
        key_t k;
        case ($urandom_range(9))
            0:       k = '0;
            1:       k = KEY_MAX;
            2:       k = KEY_MAX - $urandom_range(3);
            3, 4:    k = $urandom();
            default: k = $urandom_range(47);
        endcase
        return k;
    endfunction

    function automatic key_t pick_end(key_t k);
        key_t e;
        case ($urandom_range(7))
            0:       e = k;
            1:       e = k - 1 - $urandom_range(15);
            2:       e = KEY_MAX;
            default: e = (k <= KEY_MAX - 64) ? k + 1 + $urandom_range(62) : KEY_MAX;
        endcase
        return e;
    endfunction

    function automatic value_t pick_value();
        value_t v;
        case ($urandom_range(9))
            0:       v = 8'hFF;
            1, 2, 3: v = value_t'($urandom_range(255));
            default: v = value_t'($urandom_range(3));
        endcase
        return v;
    endfunction

    task automatic send_random_words(int count, int hold_at);
        opcode_t op;
        key_t    k;
        int      r;
        int      n;
        for (n = 0; n < count; n++)
        begin
            if (n == hold_at)
                hold_requests++;
            r = $urandom_range(99);
            if (r < 40)
                op = OP_LOOKUP;
            else if (r < 94)
                op = OP_ASSIGN;
            else if (r < 98)
                op = OP_UNUSED;
            else
                op = OP_CLEAR;
            k = pick_key();
            send_word(op, k, pick_end(k), pick_value());
        end
    endtask

    initial
    begin
        int n;
        req_ch.valid     = 1'b0;
        req_ch.opcode    = OP_LOOKUP;
        req_ch.key       = '0;
        req_ch.key_end   = '0;
        req_ch.new_value = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily.
        tx_idle_pct = 12;
        rx_idle_pct = 71;
        write_initial_value(8'hFF);

        send_word(OP_LOOKUP, '0, '0, '0);
        send_word(OP_LOOKUP, KEY_MAX, '0, 8'hFF);
        send_word(OP_ASSIGN, 32'd5, 32'd5, 8'h12);
        send_word(OP_ASSIGN, KEY_MAX, '0, 8'h34);
        send_word(OP_ASSIGN, 32'd100, 32'd200, 8'h00);
        send_word(OP_ASSIGN, 32'd100, 32'd200, 8'hAA);
        send_word(OP_UNUSED, 32'd150, '0, '0);
        send_word(OP_ASSIGN, '0, KEY_MAX, 8'hFF);
        send_word(OP_ASSIGN, KEY_MAX - 1, KEY_MAX, 8'h00);
        for (n = 0; n < 13; n++)
            send_word(OP_ASSIGN, key_t'(1000 * (n + 1)), KEY_MAX, value_t'(n + 1));
        // The table is full now: a new start key is refused, an existing one is not.
        send_word(OP_ASSIGN, 32'd500, 32'd600, 8'h33);
        send_word(OP_ASSIGN, 32'd100, 32'd101, 8'h11);
        send_word(OP_CLEAR, '0, '0, '0);

        send_random_words(PHASE_WORDS, -1);

        tx_idle_pct = 71;
        rx_idle_pct = 12;
        write_initial_value(8'h00);
        send_random_words(PHASE_WORDS, -1);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_initial_value(value_t'($urandom_range(254, 1)));
        send_random_words(PHASE_WORDS, 200);

        req_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d result words over three idling patterns and three initial values.",
                 checked_count);
        $display("Assigns refused by a full table: %0d; results held off once for %0d cycles.",
                 full_count, HOLD_CYCLES);
        if (fail_count == 0 && pending_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
